[design/vfc_pkg.sv]
package vfc_pkg;

  localparam int unsigned CoordWidthDef = 21;
  localparam int unsigned AxisWidthDef  = 16;
  localparam int unsigned SlopeWidth    = 16;
  localparam int unsigned SlopeFrac     = 8;
  localparam int unsigned NumCorners    = 8;
  localparam int unsigned LaneStages    = 5;
  localparam int unsigned RegIdxWidth   = 3;

  typedef enum logic [1:0] {
    ACT_POINT  = 2'd0,
    ACT_SPHERE = 2'd1,
    ACT_BOX    = 2'd2
  } action_e;

  typedef enum logic [RegIdxWidth-1:0] {
    REG_EYE     = 3'd0,
    REG_FORWARD = 3'd1,
    REG_RIGHT   = 3'd2,
    REG_UP      = 3'd3,
    REG_RSLOPE  = 3'd4,
    REG_USLOPE  = 3'd5,
    REG_NEAR    = 3'd6,
    REG_FAR     = 3'd7
  } reg_e;

  typedef struct packed {
    logic hit;
    logic r_lo;
    logic r_hi;
    logic u_lo;
    logic u_hi;
    logic f_lo;
    logic f_hi;
  } side_t;

endpackage

[design/vfc_lane.sv]
module vfc_lane import vfc_pkg::*; #(
  parameter int unsigned COORD_WIDTH = CoordWidthDef,
  parameter int unsigned AXIS_WIDTH  = AxisWidthDef
) (
  input  logic                       clk_i,
  input  logic [COORD_WIDTH-1:0]     px_i,
  input  logic [COORD_WIDTH-1:0]     py_i,
  input  logic [COORD_WIDTH-1:0]     pz_i,
  input  logic [COORD_WIDTH-2:0]     rad_i,
  input  logic [3*COORD_WIDTH-1:0]   eye_i,
  input  logic [3*AXIS_WIDTH-1:0]    fwd_i,
  input  logic [3*AXIS_WIDTH-1:0]    rgt_i,
  input  logic [3*AXIS_WIDTH-1:0]    up_i,
  input  logic [SlopeWidth-1:0]      rslope_i,
  input  logic [SlopeWidth-1:0]      uslope_i,
  input  logic [COORD_WIDTH-2:0]     near_i,
  input  logic [COORD_WIDTH-2:0]     far_i,
  output side_t                      side_o
);

  localparam int unsigned DW  = COORD_WIDTH + 1;
  localparam int unsigned PW  = DW + AXIS_WIDTH;
  localparam int unsigned SW  = PW + 2;
  localparam int unsigned LW  = SW + SlopeWidth + 1;
  localparam int unsigned CPW = LW + 1;

  logic [COORD_WIDTH-1:0]        pt [3];
  logic signed [DW-1:0]          d_q [3];
  logic signed [PW-1:0]          pf_q [3];
  logic signed [PW-1:0]          pr_q [3];
  logic signed [PW-1:0]          pu_q [3];
  logic signed [SW-1:0]          f_q, r_q, u_q, f2_q, r2_q, u2_q;
  logic signed [LW-1:0]          rl_q, ul_q;
  logic [COORD_WIDTH-2:0]        rad1_q, rad2_q, rad3_q, rad4_q;
  side_t                         side_q;

  logic signed [CPW-1:0] fc, rc, uc, near_s, far_s, rad_s, rad_l, rt, ut;
  logic                  f_lo, f_hi, r_lo, r_hi, u_lo, u_hi;

  assign pt[0] = px_i;
  assign pt[1] = py_i;
  assign pt[2] = pz_i;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      d_q[k] <= $signed({pt[k][COORD_WIDTH-1], pt[k]})
              - $signed({eye_i[k*COORD_WIDTH+COORD_WIDTH-1],
                         eye_i[k*COORD_WIDTH +: COORD_WIDTH]});
      pf_q[k] <= d_q[k] * $signed(fwd_i[k*AXIS_WIDTH +: AXIS_WIDTH]);
      pr_q[k] <= d_q[k] * $signed(rgt_i[k*AXIS_WIDTH +: AXIS_WIDTH]);
      pu_q[k] <= d_q[k] * $signed(up_i[k*AXIS_WIDTH +: AXIS_WIDTH]);
    end
    rad1_q <= rad_i;
    rad2_q <= rad1_q;
    rad3_q <= rad2_q;
    rad4_q <= rad3_q;
    f_q    <= SW'(pf_q[0]) + SW'(pf_q[1]) + SW'(pf_q[2]);
    r_q    <= SW'(pr_q[0]) + SW'(pr_q[1]) + SW'(pr_q[2]);
    u_q    <= SW'(pu_q[0]) + SW'(pu_q[1]) + SW'(pu_q[2]);
    rl_q   <= $signed({1'b0, rslope_i}) * f_q;
    ul_q   <= $signed({1'b0, uslope_i}) * f_q;
    f2_q   <= f_q;
    r2_q   <= r_q;
    u2_q   <= u_q;
    side_q <= '{hit: !(f_lo || f_hi || r_lo || r_hi || u_lo || u_hi),
                r_lo: r_lo, r_hi: r_hi, u_lo: u_lo, u_hi: u_hi,
                f_lo: f_lo, f_hi: f_hi};
  end

  always_comb begin
    fc     = CPW'(f2_q);
    rc     = CPW'(r2_q) <<< SlopeFrac;
    uc     = CPW'(u2_q) <<< SlopeFrac;
    near_s = CPW'(near_i) << (AXIS_WIDTH - 2);
    far_s  = CPW'(far_i) << (AXIS_WIDTH - 2);
    rad_s  = CPW'(rad4_q) << (AXIS_WIDTH - 2);
    rad_l  = rad_s << SlopeFrac;
    rt     = CPW'(rl_q) + rad_l;
    ut     = CPW'(ul_q) + rad_l;
    f_lo   = fc < (near_s - rad_s);
    f_hi   = !f_lo && (fc > (far_s + rad_s));
    r_lo   = rc < -rt;
    r_hi   = !r_lo && (rc > rt);
    u_lo   = uc < -ut;
    u_hi   = !u_lo && (uc > ut);
  end

  assign side_o = side_q;

endmodule

[design/vfc_merge.sv]
module vfc_merge import vfc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  input  action_e  action_i,
  input  side_t    side_i [NumCorners],
  output logic     done_o,
  output logic     visible_o
);

  logic done_q, vis_q, vis_d;
  logic any_in;
  logic all_rlo, all_rhi, all_ulo, all_uhi, all_flo, all_fhi;

  always_comb begin
    any_in  = 1'b0;
    all_rlo = 1'b1;
    all_rhi = 1'b1;
    all_ulo = 1'b1;
    all_uhi = 1'b1;
    all_flo = 1'b1;
    all_fhi = 1'b1;
    for (int i = 0; i < NumCorners; i++) begin
      any_in  = any_in  | side_i[i].hit;
      all_rlo = all_rlo & side_i[i].r_lo;
      all_rhi = all_rhi & side_i[i].r_hi;
      all_ulo = all_ulo & side_i[i].u_lo;
      all_uhi = all_uhi & side_i[i].u_hi;
      all_flo = all_flo & side_i[i].f_lo;
      all_fhi = all_fhi & side_i[i].f_hi;
    end
    unique case (action_i)
      ACT_POINT, ACT_SPHERE: vis_d = side_i[0].hit;
      ACT_BOX: vis_d = any_in ||
                       !(all_rlo || all_rhi || all_ulo || all_uhi || all_flo || all_fhi);
      default: vis_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    vis_q <= vis_d;
  end

  assign done_o    = done_q;
  assign visible_o = vis_q;

endmodule

[design/view_frustum_cull_test.sv]
// Throughput: one word per cycle; busy stays low, eight corner lanes
// and the merge stage are fully pipelined.
// done_o is high for one cycle and cannot be stalled.
// Reset (async, active low) clears the pipeline valid bits and loads the
// register defaults: eye and axes zero, slopes 1.0, near 256 coordinate units, far maximum.
module view_frustum_cull_test import vfc_pkg::*; #(
  parameter int unsigned COORD_WIDTH = CoordWidthDef,
  parameter int unsigned AXIS_WIDTH  = AxisWidthDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [RegIdxWidth-1:0]    cfg_index_i,
  input  logic [3*((COORD_WIDTH > AXIS_WIDTH) ? COORD_WIDTH : AXIS_WIDTH)-1:0] cfg_data_i,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                action_i,
  input  logic [COORD_WIDTH-1:0]    first_x_i,
  input  logic [COORD_WIDTH-1:0]    first_y_i,
  input  logic [COORD_WIDTH-1:0]    first_z_i,
  input  logic [COORD_WIDTH-1:0]    second_x_i,
  input  logic [COORD_WIDTH-1:0]    second_y_i,
  input  logic [COORD_WIDTH-1:0]    second_z_i,
  input  logic [COORD_WIDTH-2:0]    radius_i,
  output logic                      done_o,
  output logic                      visible_o
);

  logic [3*COORD_WIDTH-1:0] eye_q;
  logic [3*AXIS_WIDTH-1:0]  fwd_q, rgt_q, up_q;
  logic [SlopeWidth-1:0]    rslope_q, uslope_q;
  logic [COORD_WIDTH-2:0]   near_q, far_q;

  logic [LaneStages-1:0]    v_q;
  action_e                  act_q [LaneStages];
  logic                     accept;
  logic [COORD_WIDTH-2:0]   rad_eff;
  side_t                    side [NumCorners];

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign rad_eff = (action_i == ACT_SPHERE) ? radius_i : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eye_q    <= '0;
      fwd_q    <= '0;
      rgt_q    <= '0;
      up_q     <= '0;
      rslope_q <= SlopeWidth'(1 << SlopeFrac);
      uslope_q <= SlopeWidth'(1 << SlopeFrac);
      near_q   <= (COORD_WIDTH-1)'(1 << SlopeFrac);
      far_q    <= '1;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_index_i))
        REG_EYE:     eye_q    <= cfg_data_i[3*COORD_WIDTH-1:0];
        REG_FORWARD: fwd_q    <= cfg_data_i[3*AXIS_WIDTH-1:0];
        REG_RIGHT:   rgt_q    <= cfg_data_i[3*AXIS_WIDTH-1:0];
        REG_UP:      up_q     <= cfg_data_i[3*AXIS_WIDTH-1:0];
        REG_RSLOPE:  rslope_q <= cfg_data_i[SlopeWidth-1:0];
        REG_USLOPE:  uslope_q <= cfg_data_i[SlopeWidth-1:0];
        REG_NEAR:    near_q   <= cfg_data_i[COORD_WIDTH-2:0];
        REG_FAR:     far_q    <= cfg_data_i[COORD_WIDTH-2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[LaneStages-2:0], accept};
    end
  end

  always_ff @(posedge clk_i) begin
    act_q[0] <= action_e'(action_i);
    for (int s = 1; s < LaneStages; s++) begin
      act_q[s] <= act_q[s-1];
    end
  end

  for (genvar g = 0; g < NumCorners; g++) begin : g_lane
    vfc_lane #(
      .COORD_WIDTH (COORD_WIDTH),
      .AXIS_WIDTH  (AXIS_WIDTH)
    ) u_lane (
      .clk_i    (clk_i),
      .px_i     (((g & 1) != 0) ? second_x_i : first_x_i),
      .py_i     (((g & 4) != 0) ? second_y_i : first_y_i),
      .pz_i     (((g & 2) != 0) ? second_z_i : first_z_i),
      .rad_i    (rad_eff),
      .eye_i    (eye_q),
      .fwd_i    (fwd_q),
      .rgt_i    (rgt_q),
      .up_i     (up_q),
      .rslope_i (rslope_q),
      .uslope_i (uslope_q),
      .near_i   (near_q),
      .far_i    (far_q),
      .side_o   (side[g])
    );
  end

  vfc_merge u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (v_q[LaneStages-1]),
    .action_i  (act_q[LaneStages-1]),
    .side_i    (side),
    .done_o    (done_o),
    .visible_o (visible_o)
  );

endmodule

[design/vfc_checker.sv]
module vfc_checker import vfc_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic [1:0] action_i,
  input logic       done_o,
  input logic       visible_o
);

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##6 done_o) else $error("missing done strobe");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 6)) else $error("spurious done strobe");

  a_bad_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(action_i, 6) == 2'd3) |-> !visible_o)
    else $error("unused action reported visible");

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy) else $error("busy raised");

endmodule

bind view_frustum_cull_test vfc_checker u_vfc_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .start     (start),
  .busy      (busy),
  .action_i  (action_i),
  .done_o    (done_o),
  .visible_o (visible_o)
);

[test/view_frustum_cull_test_tb.sv]
module view_frustum_cull_test_tb;
  import vfc_pkg::*;

  localparam int unsigned CW = CoordWidthDef;
  localparam int unsigned AW = AxisWidthDef;
  localparam int unsigned DW = 3 * ((CW > AW) ? CW : AW);
  localparam int unsigned AFRAC = AW - 2;
  localparam int unsigned FIELD_IDLE_PCT = 33;

  typedef struct {
    logic [1:0] action;
    logic [CW-1:0] ax, ay, az, bx, by, bz;
    logic [CW-2:0] radius;
  } query_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [RegIdxWidth-1:0] cfg_index_i = REG_EYE;
  logic [DW-1:0] cfg_data_i = '0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] action_i = ACT_POINT;
  logic [CW-1:0] first_x_i = '0, first_y_i = '0, first_z_i = '0;
  logic [CW-1:0] second_x_i = '0, second_y_i = '0, second_z_i = '0;
  logic [CW-2:0] radius_i = '0;
  logic done_o, visible_o;

  view_frustum_cull_test uut (.*);

  always #1 clk_i = ~clk_i;

  // frustum copy
  longint eye [3], fwd [3], rgt [3], upv [3];
  longint rslope, uslope, near_d, far_d;

  query_t pending_q [$];
  bit visible_q [$];
  int errors = 0;
  int checked = 0;
  int phases = 0;
  bit calm = 0;

  function automatic longint sx(logic [63:0] v, int w);
    longint x;
    x = v & ((64'd1 << w) - 1);
    if (v[w-1]) x -= (longint'(1) << w);
    return x;
  endfunction

  function automatic void set_frustum(reg_e idx, logic [DW-1:0] v);
    case (idx)
      REG_EYE:     for (int i = 0; i < 3; i++) eye[i] = sx(v >> (i*CW), CW);
      REG_FORWARD: for (int i = 0; i < 3; i++) fwd[i] = sx(v >> (i*AW), AW);
      REG_RIGHT:   for (int i = 0; i < 3; i++) rgt[i] = sx(v >> (i*AW), AW);
      REG_UP:      for (int i = 0; i < 3; i++) upv[i] = sx(v >> (i*AW), AW);
      REG_RSLOPE:  rslope = v[15:0];
      REG_USLOPE:  uslope = v[15:0];
      REG_NEAR:    near_d = v[CW-2:0];
      REG_FAR:     far_d = v[CW-2:0];
      default: ;
    endcase
  endfunction

  function automatic longint dot(longint d [3], longint a [3]);
    return d[0]*a[0] + d[1]*a[1] + d[2]*a[2];
  endfunction

  function automatic int side(longint v, longint lo, longint hi);
    if (v < lo) return 0;
    if (v > hi) return 2;
    return 1;
  endfunction

  function automatic bit predict_visible(query_t q);
    longint a [3], b [3], p [3];
    longint ns, fs, rs, rl, f, r, u, rt, ut;
    int cnt [3][3];
    int sr, su, sf;
    a[0] = sx(q.ax, CW) - eye[0]; a[1] = sx(q.ay, CW) - eye[1];
    a[2] = sx(q.az, CW) - eye[2];
    b[0] = sx(q.bx, CW) - eye[0]; b[1] = sx(q.by, CW) - eye[1];
    b[2] = sx(q.bz, CW) - eye[2];
    ns = near_d <<< AFRAC;
    fs = far_d <<< AFRAC;
    rs = longint'(q.radius) <<< AFRAC;
    rl = (q.action == ACT_SPHERE) ? (rs <<< SlopeFrac) : 0;
    if (q.action == ACT_POINT || q.action == ACT_SPHERE) begin
      if (q.action == ACT_POINT) rs = 0;
      f = dot(a, fwd);
      r = dot(a, rgt) <<< SlopeFrac;
      u = dot(a, upv) <<< SlopeFrac;
      rt = rslope * f + rl;
      ut = uslope * f + rl;
      if (f < ns - rs || f > fs + rs) return 0;
      if (r < -rt || r > rt) return 0;
      if (u < -ut || u > ut) return 0;
      return 1;
    end
    if (q.action != ACT_BOX) return 0;
    foreach (cnt[i, j]) cnt[i][j] = 0;
    for (int i = 0; i < NumCorners; i++) begin
      p[0] = i[0] ? b[0] : a[0];
      p[1] = i[2] ? b[1] : a[1];
      p[2] = i[1] ? b[2] : a[2];
      f = dot(p, fwd);
      r = dot(p, rgt) <<< SlopeFrac;
      u = dot(p, upv) <<< SlopeFrac;
      sr = side(r, -(rslope * f), rslope * f);
      su = side(u, -(uslope * f), uslope * f);
      sf = side(f, ns, fs);
      if (sr == 1 && su == 1 && sf == 1) return 1;
      cnt[0][sr]++; cnt[1][su]++; cnt[2][sf]++;
    end
    for (int i = 0; i < 3; i++)
      if (cnt[i][0] == NumCorners || cnt[i][2] == NumCorners) return 0;
    return 1;
  endfunction

  task automatic report_mismatch(string what);
    errors++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  // driver
  always @(negedge clk_i) begin
    query_t q;
    if (start && !busy) begin
      q = pending_q.pop_front();
      visible_q.push_back(predict_visible(q));
    end
    if (pending_q.size() > 0 && rst_ni && (calm || $urandom_range(99) >= FIELD_IDLE_PCT))
    begin
      q = pending_q[0];
      start <= 1'b1;
      action_i <= q.action;
      first_x_i <= q.ax; first_y_i <= q.ay; first_z_i <= q.az;
      second_x_i <= q.bx; second_y_i <= q.by; second_z_i <= q.bz;
      radius_i <= q.radius;
    end else begin
      start <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (done_o) begin
      if (visible_q.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        bit expd;
        expd = visible_q.pop_front();
        checked++;
        if (visible_o !== expd)
          report_mismatch($sformatf("visible %b, expected %b", visible_o, expd));
      end
    end
  end

  function automatic logic [CW-1:0] rnd_coord(int mode);
    case (mode)
      0: return CW'($urandom);
      1: return CW'($signed($urandom_range(0, 8192)) - 4096);
      default: return CW'($signed($urandom_range(0, 1 << 16)) - (1 << 15));
    endcase
  endfunction

  function automatic query_t rnd_query();
    query_t q;
    int m;
    m = $urandom_range(2);
    q.action = ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2));
    q.ax = rnd_coord(m); q.ay = rnd_coord(m); q.az = rnd_coord(m);
    q.bx = rnd_coord(m); q.by = rnd_coord(m); q.bz = rnd_coord(m);
    if ($urandom_range(1)) begin
      if ($signed(q.bx) < $signed(q.ax)) {q.ax, q.bx} = {q.bx, q.ax};
      if ($signed(q.by) < $signed(q.ay)) {q.ay, q.by} = {q.by, q.ay};
      if ($signed(q.bz) < $signed(q.az)) {q.az, q.bz} = {q.bz, q.az};
    end
    q.radius = (m == 0) ? (CW-1)'($urandom) : (CW-1)'($urandom_range(0, 4096));
    return q;
  endfunction

  task automatic write_reg(reg_e idx, logic [DW-1:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    set_frustum(idx, v);
  endtask

  task automatic wait_sent();
    while (pending_q.size() > 0) @(negedge clk_i);
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || visible_q.size() > 0) @(negedge clk_i);
    repeat (LaneStages + 4) @(negedge clk_i);
  endtask

  function automatic logic [DW-1:0] pack_axis(int x, int y, int z);
    return DW'({AW'(z), AW'(y), AW'(x)});
  endfunction

  task automatic load_frustum(int kind);
    logic [DW-1:0] e;
    case (kind)
      0: begin
        write_reg(REG_EYE, '0);
        write_reg(REG_FORWARD, pack_axis(0, 0, 1 << AFRAC));
        write_reg(REG_RIGHT, pack_axis(1 << AFRAC, 0, 0));
        write_reg(REG_UP, pack_axis(0, 1 << AFRAC, 0));
        write_reg(REG_RSLOPE, DW'(256));
        write_reg(REG_USLOPE, DW'(128));
        write_reg(REG_NEAR, DW'(256));
        write_reg(REG_FAR, DW'(256 * 20));
      end
      1: begin
        e = {CW'(-200), CW'(300), CW'(-100)};
        write_reg(REG_EYE, e);
        write_reg(REG_FORWARD, pack_axis(-(1 << AFRAC), 0, 0));
        write_reg(REG_RIGHT, pack_axis(0, 0, 1 << AFRAC));
        write_reg(REG_UP, pack_axis(0, -(1 << AFRAC), 0));
        write_reg(REG_RSLOPE, DW'(16'hffff));
        write_reg(REG_USLOPE, '0);
        write_reg(REG_NEAR, '0);
        write_reg(REG_FAR, DW'((1 << (CW-1)) - 1));
      end
      2: begin
        write_reg(REG_EYE, DW'({$urandom, $urandom}));
        write_reg(REG_FORWARD, DW'({$urandom, $urandom}));
        write_reg(REG_RIGHT, DW'({$urandom, $urandom}));
        write_reg(REG_UP, DW'({$urandom, $urandom}));
        write_reg(REG_RSLOPE, DW'({$urandom, $urandom}));
        write_reg(REG_USLOPE, DW'({$urandom, $urandom}));
        write_reg(REG_NEAR, DW'({$urandom, $urandom}));
        write_reg(REG_FAR, DW'({$urandom, $urandom}));
      end
      default: begin
        write_reg(REG_EYE, {3{1'b1, {(CW-1){1'b0}}}});
        write_reg(REG_FORWARD, pack_axis(11585, 0, 11585));
        write_reg(REG_RIGHT, pack_axis(11585, 0, -11585));
        write_reg(REG_UP, DW'({3*AW{1'b1}}));
        write_reg(REG_RSLOPE, DW'(512));
        write_reg(REG_USLOPE, DW'(512));
        write_reg(REG_NEAR, DW'((1 << (CW-1)) - 1));
        write_reg(REG_FAR, '0);
      end
    endcase
  endtask

  initial begin
    query_t q;
    logic [CW-1:0] mx, mn;
    set_frustum(REG_EYE, '0); set_frustum(REG_FORWARD, '0);
    set_frustum(REG_RIGHT, '0); set_frustum(REG_UP, '0);
    set_frustum(REG_RSLOPE, DW'(256)); set_frustum(REG_USLOPE, DW'(256));
    set_frustum(REG_NEAR, DW'(256)); set_frustum(REG_FAR, DW'((1 << (CW-1)) - 1));
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // defaults after reset: zero axes
    q = '{action: ACT_POINT, default: '0};
    pending_q.push_back(q);
    drain();
    load_frustum(0);
    mx = {1'b0, {(CW-1){1'b1}}};
    mn = {1'b1, {(CW-1){1'b0}}};
    calm = 1;
    pending_q.push_back('{ACT_POINT, 0, 0, 2560, 0, 0, 0, 0});
    pending_q.push_back('{ACT_POINT, 2560, 0, 2560, mx, mx, mx, '1});
    pending_q.push_back('{ACT_POINT, 2561, 0, 2560, 0, 0, 0, 0});
    pending_q.push_back('{ACT_POINT, 0, 1280, 2560, 0, 0, 0, 0});
    pending_q.push_back('{ACT_POINT, 0, 0, 100, 0, 0, 0, 0});
    pending_q.push_back('{ACT_POINT, mx, mx, mx, 0, 0, 0, 0});
    pending_q.push_back('{ACT_POINT, mn, mn, mn, 0, 0, 0, 0});
    pending_q.push_back('{ACT_SPHERE, 0, 0, 100, mn, mn, mn, 200});
    pending_q.push_back('{ACT_SPHERE, 0, 3000, 2560, 0, 0, 0, 200});
    pending_q.push_back('{ACT_SPHERE, 4000, 0, 2560, 0, 0, 0, 2000});
    pending_q.push_back('{ACT_SPHERE, mn, mn, mn, 0, 0, 0, '1});
    pending_q.push_back('{ACT_SPHERE, 0, 0, -2560, 0, 0, 0, 0});
    pending_q.push_back('{ACT_BOX, -100, -100, 1000, 100, 100, 2000, 0});
    pending_q.push_back('{ACT_BOX, -9000, -9000, 1000, 9000, 9000, 2000, 0});
    pending_q.push_back('{ACT_BOX, 9000, 0, 1000, 9500, 100, 2000, 0});
    pending_q.push_back('{ACT_BOX, 100, 100, 2000, -100, -100, 1000, 0});
    pending_q.push_back('{ACT_BOX, mn, mn, mn, mx, mx, mx, '1});
    pending_q.push_back('{ACT_BOX, 0, 0, -5000, 10, 10, -4000, 0});
    pending_q.push_back('{2'd3, 0, 0, 2560, 0, 0, 0, 0});
    drain();
    for (int ph = 1; ph <= 5; ph++) begin
      load_frustum(ph % 4);
      phases++;
      calm = 0;
      for (int n = 0; n < 100; n++) pending_q.push_back(rnd_query());
      wait_sent();
      calm = 1;
      for (int n = 0; n < 60; n++) pending_q.push_back(rnd_query());
      wait_sent();
      calm = 0;
      for (int n = 0; n < 60; n++) pending_q.push_back(rnd_query());
      drain();
    end
    $display("checked %0d culling queries over %0d frustum settings", checked, phases + 1);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end

endmodule

[files.f]
design/vfc_pkg.sv
design/vfc_lane.sv
design/vfc_merge.sv
design/view_frustum_cull_test.sv
design/vfc_checker.sv
test/view_frustum_cull_test_tb.sv
